// ----- rtl/ctrb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctrb_pkg: shared definitions for the cyclic timer relay
// Mode codes, setup timing constants, configuration register indexes and
// the period arithmetic used by the relay core.
// ----------------------------------------------------------------------------
package ctrb_pkg;

   localparam int unsigned VALUE_WIDTH   = 8;
   localparam int unsigned PERIOD_WIDTH  = 22;
   localparam int unsigned SLOT_WIDTH    = 3;
   localparam int unsigned REG_COUNT     = 6;
   localparam int unsigned INDEX_WIDTH   = 3;

   // Blink and entry timing, in quarter-second ticks.
   localparam logic [7:0] BLINK_TICKS         = 8'd1;
   localparam logic [7:0] ENTRY_TIMEOUT_TICKS = 8'd12;
   localparam logic [2:0] FEEDBACK_BLINKS     = 3'd5;
   localparam logic [2:0] VALUE_COUNT         = 3'd6;

   // Ticks per unit of each period digit.
   localparam logic [PERIOD_WIDTH-1:0] TICKS_PER_HOUR   = 22'd14400;
   localparam logic [PERIOD_WIDTH-1:0] TICKS_PER_MINUTE = 22'd240;
   localparam logic [PERIOD_WIDTH-1:0] TICKS_PER_SECOND = 22'd4;

   typedef enum logic [1:0] {
      MODE_CYCLE = 2'd0,
      MODE_BLINK = 2'd1,
      MODE_ENTRY = 2'd2
   } mode_type;

   typedef enum logic [INDEX_WIDTH-1:0] {
      REG_ON_HOURS    = 3'd0,
      REG_ON_MINUTES  = 3'd1,
      REG_ON_SECONDS  = 3'd2,
      REG_OFF_HOURS   = 3'd3,
      REG_OFF_MINUTES = 3'd4,
      REG_OFF_SECONDS = 3'd5
   } reg_index_type;

   typedef logic [VALUE_WIDTH-1:0] value_type;

   // Power-up register values.
   localparam value_type RESET_ON_HOURS    = 8'd0;
   localparam value_type RESET_ON_MINUTES  = 8'd0;
   localparam value_type RESET_ON_SECONDS  = 8'd1;
   localparam value_type RESET_OFF_HOURS   = 8'd0;
   localparam value_type RESET_OFF_MINUTES = 8'd0;
   localparam value_type RESET_OFF_SECONDS = 8'd1;

   function automatic logic [PERIOD_WIDTH-1:0] period_ticks(
      input value_type hours,
      input value_type minutes,
      input value_type seconds
   );
      logic [PERIOD_WIDTH-1:0] sum;
      sum = PERIOD_WIDTH'(hours) * TICKS_PER_HOUR
          + PERIOD_WIDTH'(minutes) * TICKS_PER_MINUTE
          + PERIOD_WIDTH'(seconds) * TICKS_PER_SECOND;
      return sum;
   endfunction

endpackage

// ----- rtl/cyclic_timer_relay_with_button_setup_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cyclic_timer_relay_with_button_setup_core: cyclic relay timer with setup
// Runs the relay on/off cycle, the blink feedback and the digit entry of the
// button setup, one input transaction at a time.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries one transaction per clock at most: a tick flag,
//   a press event and the held level of the button. Each accepted
//   transaction yields exactly one rsp_ transaction with the relay and LED
//   levels, the mode, and a store write request when a setup value is saved.
//   The csr_ port writes the six power-up period registers; write only while
//   no transaction is in flight.
//   rsp_valid rises in the cycle after acceptance; throughput is one
//   transaction per cycle unless rsp_stall holds a waiting result. The next
//   state and result take one pass of logic from state to result registers;
//   the period reload (three constant multiplies, two adds) sets the clock.
//   Reset puts the block in the on phase with the on period loaded from the
//   reset register values, and empties the result register.
//   While rsp_stall holds a waiting result, req_stall rises and no further
//   transaction is taken; a result taken in the same cycle frees the slot.
// ----------------------------------------------------------------------------
module cyclic_timer_relay_with_button_setup_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_tick,
   input  logic                                   req_press,
   input  logic                                   req_button_held,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_relay_on,
   output logic                                   rsp_led_on,
   output logic [1:0]                             rsp_mode,
   output logic                                   rsp_store_valid,
   output logic [ctrb_pkg::SLOT_WIDTH-1:0]        rsp_store_slot,
   output logic [ctrb_pkg::VALUE_WIDTH-1:0]       rsp_store_value,
   input  logic                                   csr_write_enable,
   input  logic [ctrb_pkg::INDEX_WIDTH-1:0]       csr_index,
   input  logic [ctrb_pkg::VALUE_WIDTH-1:0]       csr_write_data
);

   localparam int unsigned PW = ctrb_pkg::PERIOD_WIDTH;
   localparam int unsigned SW = ctrb_pkg::SLOT_WIDTH;
   localparam int unsigned NR = ctrb_pkg::REG_COUNT;

   // Configuration registers.
   ctrb_pkg::value_type cfg_ff [NR];

   // Control state.
   ctrb_pkg::mode_type   mode_ff, mode_in;
   logic                 on_phase_ff, on_phase_in;
   logic [PW-1:0]        countdown_ff, countdown_in;
   logic [7:0]           fixed_ff, fixed_in;
   logic                 led_lit_ff, led_lit_in;
   logic [2:0]           blinks_ff, blinks_in;
   logic [2:0]           values_ff, values_in;
   ctrb_pkg::value_type  digit_ff, digit_in;
   ctrb_pkg::value_type  entered_ff [NR];
   ctrb_pkg::value_type  entered_in [NR];
   logic                 use_entered_ff, use_entered_in;

   // Result register.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 relay_ff, relay_in;
   logic                 led_ff, led_in;
   logic [1:0]           mode_out_ff, mode_out_in;
   logic                 store_valid_ff, store_valid_in;
   logic [SW-1:0]        store_slot_ff, store_slot_in;
   ctrb_pkg::value_type  store_value_ff, store_value_in;

   logic                 accept;
   logic [PW-1:0]        on_period;
   logic [PW-1:0]        off_period;
   logic [SW-1:0]        slot;

   // The input side waits only while a result is held back by the receiver.
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      if (use_entered_ff) begin
         on_period  = ctrb_pkg::period_ticks(entered_ff[0], entered_ff[1], entered_ff[2]);
         off_period = ctrb_pkg::period_ticks(entered_ff[3], entered_ff[4], entered_ff[5]);
      end else begin
         on_period  = ctrb_pkg::period_ticks(cfg_ff[0], cfg_ff[1], cfg_ff[2]);
         off_period = ctrb_pkg::period_ticks(cfg_ff[3], cfg_ff[4], cfg_ff[5]);
      end
   end

   always_comb begin
      mode_in        = mode_ff;
      on_phase_in    = on_phase_ff;
      countdown_in   = countdown_ff;
      fixed_in       = fixed_ff;
      led_lit_in     = led_lit_ff;
      blinks_in      = blinks_ff;
      values_in      = values_ff;
      digit_in       = digit_ff;
      use_entered_in = use_entered_ff;
      for (int i = 0; i < NR; i++) begin
         entered_in[i] = entered_ff[i];
      end
      store_valid_in = 1'b0;
      store_slot_in  = '0;
      store_value_in = '0;
      slot           = '0;

      case (mode_ff)
         ctrb_pkg::MODE_BLINK: begin
            if (req_tick) begin
               if (fixed_ff <= 8'd1) begin
                  if (led_lit_ff) begin
                     led_lit_in = 1'b0;
                     blinks_in  = blinks_ff - 3'd1;
                     if (blinks_in == 3'd0) begin
                        if (values_ff == 3'd0) begin
                           mode_in      = ctrb_pkg::MODE_CYCLE;
                           on_phase_in  = 1'b1;
                           countdown_in = on_period;
                        end else begin
                           mode_in  = ctrb_pkg::MODE_ENTRY;
                           digit_in = '0;
                           fixed_in = ctrb_pkg::ENTRY_TIMEOUT_TICKS;
                        end
                     end else begin
                        fixed_in = ctrb_pkg::BLINK_TICKS;
                     end
                  end else begin
                     led_lit_in = 1'b1;
                     fixed_in   = ctrb_pkg::BLINK_TICKS;
                  end
               end else begin
                  fixed_in = fixed_ff - 8'd1;
               end
            end
         end
         ctrb_pkg::MODE_ENTRY: begin
            if (req_press) begin
               digit_in = digit_ff + 8'd1;
               fixed_in = ctrb_pkg::ENTRY_TIMEOUT_TICKS;
            end else if (req_tick) begin
               if (fixed_ff <= 8'd1) begin
                  // Timeout: save the digit, request a store write, blink again.
                  values_in = values_ff - 3'd1;
                  slot      = (ctrb_pkg::VALUE_COUNT - 3'd1) - values_in;
                  for (int i = 0; i < NR; i++) begin
                     if (slot == SW'(i)) begin
                        entered_in[i] = digit_ff;
                     end
                  end
                  store_valid_in = 1'b1;
                  store_slot_in  = slot;
                  store_value_in = digit_ff;
                  if (values_in == 3'd0) begin
                     use_entered_in = 1'b1;
                  end
                  mode_in    = ctrb_pkg::MODE_BLINK;
                  blinks_in  = ctrb_pkg::FEEDBACK_BLINKS;
                  led_lit_in = 1'b0;
                  fixed_in   = ctrb_pkg::BLINK_TICKS;
               end else begin
                  fixed_in = fixed_ff - 8'd1;
               end
            end
         end
         default: begin
            // Cycling; an unused mode code falls back to cycling as well.
            mode_in = ctrb_pkg::MODE_CYCLE;
            if (req_press) begin
               values_in  = ctrb_pkg::VALUE_COUNT;
               mode_in    = ctrb_pkg::MODE_BLINK;
               blinks_in  = ctrb_pkg::FEEDBACK_BLINKS;
               led_lit_in = 1'b0;
               fixed_in   = ctrb_pkg::BLINK_TICKS;
            end else if (req_tick) begin
               if (countdown_ff <= PW'(1)) begin
                  on_phase_in  = ~on_phase_ff;
                  countdown_in = on_phase_in ? on_period : off_period;
               end else begin
                  countdown_in = countdown_ff - PW'(1);
               end
            end
         end
      endcase

      case (mode_in)
         ctrb_pkg::MODE_CYCLE: begin
            relay_in = on_phase_in;
            led_in   = on_phase_in;
         end
         ctrb_pkg::MODE_BLINK: begin
            relay_in = 1'b0;
            led_in   = led_lit_in;
         end
         default: begin
            relay_in = 1'b0;
            led_in   = req_button_held;
         end
      endcase
      mode_out_in = mode_in;
   end

   assign rsp_valid_in = accept | req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff[ctrb_pkg::REG_ON_HOURS]    <= ctrb_pkg::RESET_ON_HOURS;
         cfg_ff[ctrb_pkg::REG_ON_MINUTES]  <= ctrb_pkg::RESET_ON_MINUTES;
         cfg_ff[ctrb_pkg::REG_ON_SECONDS]  <= ctrb_pkg::RESET_ON_SECONDS;
         cfg_ff[ctrb_pkg::REG_OFF_HOURS]   <= ctrb_pkg::RESET_OFF_HOURS;
         cfg_ff[ctrb_pkg::REG_OFF_MINUTES] <= ctrb_pkg::RESET_OFF_MINUTES;
         cfg_ff[ctrb_pkg::REG_OFF_SECONDS] <= ctrb_pkg::RESET_OFF_SECONDS;
      end else if (csr_write_enable) begin
         for (int i = 0; i < NR; i++) begin
            if (csr_index == ctrb_pkg::INDEX_WIDTH'(i)) begin
               cfg_ff[i] <= csr_write_data;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= ctrb_pkg::MODE_CYCLE;
         on_phase_ff    <= 1'b1;
         countdown_ff   <= ctrb_pkg::period_ticks(ctrb_pkg::RESET_ON_HOURS,
                                                  ctrb_pkg::RESET_ON_MINUTES,
                                                  ctrb_pkg::RESET_ON_SECONDS);
         fixed_ff       <= '0;
         led_lit_ff     <= 1'b0;
         blinks_ff      <= '0;
         values_ff      <= '0;
         digit_ff       <= '0;
         use_entered_ff <= 1'b0;
         for (int i = 0; i < NR; i++) begin
            entered_ff[i] <= '0;
         end
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            mode_ff        <= mode_in;
            on_phase_ff    <= on_phase_in;
            countdown_ff   <= countdown_in;
            fixed_ff       <= fixed_in;
            led_lit_ff     <= led_lit_in;
            blinks_ff      <= blinks_in;
            values_ff      <= values_in;
            digit_ff       <= digit_in;
            use_entered_ff <= use_entered_in;
            for (int i = 0; i < NR; i++) begin
               entered_ff[i] <= entered_in[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         relay_ff       <= relay_in;
         led_ff         <= led_in;
         mode_out_ff    <= mode_out_in;
         store_valid_ff <= store_valid_in;
         store_slot_ff  <= store_slot_in;
         store_value_ff <= store_value_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_relay_on    = relay_ff;
   assign rsp_led_on      = led_ff;
   assign rsp_mode        = mode_out_ff;
   assign rsp_store_valid = store_valid_ff;
   assign rsp_store_slot  = store_slot_ff;
   assign rsp_store_value = store_value_ff;

endmodule
